[rtl/lz77trd_pkg.sv]
// ----------------------------------------------------------------------------
// lz77trd_pkg
// Shared constants and types for the text record decoder: history size,
// byte classes, output source selection and the controller/datapath links.
// ----------------------------------------------------------------------------
package lz77trd_pkg;

    localparam int HISTORY_DEPTH = 2048;
    localparam int HIST_AW       = $clog2(HISTORY_DEPTH);
    localparam int CNT_W         = 11;
    localparam int LEN_W         = 4;

    localparam logic [CNT_W-1:0] COUNT_MAX  = 11'h7FF;
    localparam logic [7:0]       RAW_MAX    = 8'h08;
    localparam logic [7:0]       LIT_LOW    = 8'h09;
    localparam logic [7:0]       LIT_HIGH   = 8'h7F;
    localparam logic [7:0]       PAIR_HIGH  = 8'hBF;
    localparam logic [7:0]       SPACE_BYTE = 8'h20;
    localparam logic [7:0]       FLIP_MASK  = 8'h80;
    localparam logic [LEN_W-1:0] LEN_BIAS   = 4'd3;

    typedef enum logic [2:0] {
        KIND_NONE  = 3'd0,
        KIND_EMIT  = 3'd1,
        KIND_SPACE = 3'd2,
        KIND_COPY  = 3'd3,
        KIND_BAD   = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        SEL_IN    = 3'd0,
        SEL_SPACE = 3'd1,
        SEL_FLIP  = 3'd2,
        SEL_HIST  = 3'd3,
        SEL_ERR   = 3'd4
    } out_sel_t;

    typedef struct packed {
        logic     take_in;
        logic     load_out;
        out_sel_t out_sel;
        logic     out_last;
        logic     copy_step;
    } ctrl_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  out_free;
        logic  copy_last;
    } dp_status_t;

endpackage

[rtl/lz77trd_dp.sv]
// ----------------------------------------------------------------------------
// lz77trd_dp
// Datapath: byte classification, record state, history memory, copy length
// counter and the output register.
// ----------------------------------------------------------------------------
module lz77trd_dp
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [7:0]             in_byte,
    input  logic                   in_sor,
    input  lz77trd_pkg::ctrl_cmd_t cmd,
    output lz77trd_pkg::dp_status_t st,
    output logic                   out_valid,
    output logic [7:0]             out_byte,
    output logic                   out_last,
    output logic                   out_bad,
    input  logic                   out_ready
);
    import lz77trd_pkg::*;

    logic [7:0]         hist_mem [HISTORY_DEPTH];
    logic [7:0]         rd_data_reg;
    logic [HIST_AW-1:0] rd_addr;
    logic [HIST_AW-1:0] dist_ext;

    logic [HIST_AW-1:0] wp_reg, wp_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [3:0]         raw_reg, raw_next;
    logic               pair_reg, pair_next;
    logic [5:0]         pair_hi_reg, pair_hi_next;
    logic               err_reg, err_next;
    logic [CNT_W-1:0]   dist_reg, dist_next;
    logic [LEN_W-1:0]   copy_cnt_reg, copy_cnt_next;
    logic [7:0]         byte_reg, byte_next;
    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_byte_reg, out_byte_next;
    logic               out_last_reg, out_last_next;
    logic               out_bad_reg, out_bad_next;

    logic               eff_err;
    logic               eff_pair;
    logic [3:0]         eff_raw;
    logic [CNT_W-1:0]   eff_cnt;
    logic [CNT_W-1:0]   in_dist;
    logic [LEN_W-1:0]   in_len;
    logic               is_lit;
    logic               is_announce;
    logic               is_pair_open;
    kind_t              kind;
    logic               hist_wr;
    logic [7:0]         emit_byte;
    logic [CNT_W-1:0]   cnt_base;

    // effective state once a record start has cleared it
    assign eff_err  = in_sor ? 1'b0 : err_reg;
    assign eff_pair = in_sor ? 1'b0 : pair_reg;
    assign eff_raw  = in_sor ? 4'd0 : raw_reg;
    assign eff_cnt  = in_sor ? '0 : cnt_reg;

    assign in_dist      = {pair_hi_reg, in_byte[7:3]};
    assign in_len       = {1'b0, in_byte[2:0]} + LEN_BIAS;
    assign is_lit       = (in_byte == 8'h00) || ((in_byte >= LIT_LOW) && (in_byte <= LIT_HIGH));
    assign is_announce  = (in_byte != 8'h00) && (in_byte <= RAW_MAX);
    assign is_pair_open = (in_byte > LIT_HIGH) && (in_byte <= PAIR_HIGH);

    always_comb
    begin
        kind = KIND_NONE;
        if (eff_err)
        begin
            kind = KIND_NONE;
        end
        else if (eff_pair)
        begin
            if ((in_dist == '0) || (in_dist > eff_cnt))
            begin
                kind = KIND_BAD;
            end
            else
            begin
                kind = KIND_COPY;
            end
        end
        else if ((eff_raw != 4'd0) || is_lit)
        begin
            kind = KIND_EMIT;
        end
        else if (is_announce || is_pair_open)
        begin
            kind = KIND_NONE;
        end
        else
        begin
            kind = KIND_SPACE;
        end
    end

    assign st.kind      = kind;
    assign st.out_free  = !out_valid_reg || out_ready;
    assign st.copy_last = (copy_cnt_reg == LEN_W'(1));

    always_comb
    begin
        unique case (cmd.out_sel)
            SEL_IN:    emit_byte = in_byte;
            SEL_SPACE: emit_byte = SPACE_BYTE;
            SEL_FLIP:  emit_byte = byte_reg ^ FLIP_MASK;
            SEL_HIST:  emit_byte = rd_data_reg;
            SEL_ERR:   emit_byte = 8'h00;
            default:   emit_byte = 8'h00;
        endcase
    end

    assign hist_wr = cmd.load_out && (cmd.out_sel != SEL_ERR);

    // history read address: write pointer minus distance, wrapped
    assign dist_ext = HIST_AW'(dist_reg);
    assign rd_addr  = (wp_reg >= dist_ext) ? (wp_reg - dist_ext)
                                           : (wp_reg + HIST_AW'(HISTORY_DEPTH) - dist_ext);

    always_comb
    begin
        wp_next        = wp_reg;
        cnt_base       = cmd.take_in ? eff_cnt : cnt_reg;
        cnt_next       = cnt_base;
        raw_next       = raw_reg;
        pair_next      = pair_reg;
        pair_hi_next   = pair_hi_reg;
        err_next       = err_reg;
        dist_next      = dist_reg;
        copy_cnt_next  = copy_cnt_reg;
        byte_next      = byte_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_bad_next   = out_bad_reg;

        if (cmd.take_in)
        begin
            byte_next = in_byte;
            raw_next  = eff_raw;
            pair_next = eff_pair;
            err_next  = eff_err;
            if (!eff_err)
            begin
                if (eff_pair)
                begin
                    pair_next = 1'b0;
                    if (kind == KIND_BAD)
                    begin
                        err_next = 1'b1;
                    end
                    dist_next     = in_dist;
                    copy_cnt_next = in_len;
                end
                else if (eff_raw != 4'd0)
                begin
                    raw_next = eff_raw - 4'd1;
                end
                else if (is_announce)
                begin
                    raw_next = in_byte[3:0];
                end
                else if (is_pair_open)
                begin
                    pair_next    = 1'b1;
                    pair_hi_next = in_byte[5:0];
                end
            end
        end

        if (cmd.copy_step)
        begin
            copy_cnt_next = copy_cnt_reg - LEN_W'(1);
        end

        if (hist_wr)
        begin
            wp_next = (wp_reg == HIST_AW'(HISTORY_DEPTH - 1)) ? '0 : wp_reg + HIST_AW'(1);
            if (cnt_base < COUNT_MAX)
            begin
                cnt_next = cnt_base + CNT_W'(1);
            end
        end

        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = emit_byte;
            out_last_next  = cmd.out_last;
            out_bad_next   = (cmd.out_sel == SEL_ERR);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            cnt_reg       <= '0;
            raw_reg       <= '0;
            pair_reg      <= 1'b0;
            pair_hi_reg   <= '0;
            err_reg       <= 1'b0;
            copy_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wp_reg        <= wp_next;
            cnt_reg       <= cnt_next;
            raw_reg       <= raw_next;
            pair_reg      <= pair_next;
            pair_hi_reg   <= pair_hi_next;
            err_reg       <= err_next;
            copy_cnt_reg  <= copy_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dist_reg     <= dist_next;
        byte_reg     <= byte_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_bad_reg  <= out_bad_next;
    end

    always_ff @(posedge clk)
    begin
        if (hist_wr)
        begin
            hist_mem[wp_reg] <= emit_byte;
        end
        rd_data_reg <= hist_mem[rd_addr];
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;
    assign out_bad   = out_bad_reg;

endmodule

[rtl/lz77trd_ctrl.sv]
// ----------------------------------------------------------------------------
// lz77trd_ctrl
// Controller: sequences input acceptance, the space-plus-byte pair and the
// read/write steps of a history copy.
// ----------------------------------------------------------------------------
module lz77trd_ctrl
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  lz77trd_pkg::dp_status_t st,
    output lz77trd_pkg::ctrl_cmd_t  cmd
);
    import lz77trd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_SPACE2  = 4'b0010,
        S_COPY_RD = 4'b0100,
        S_COPY_WR = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next    = state_reg;
        in_ready      = 1'b0;
        cmd.take_in   = 1'b0;
        cmd.load_out  = 1'b0;
        cmd.out_sel   = SEL_IN;
        cmd.out_last  = 1'b0;
        cmd.copy_step = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = st.out_free;
                if (in_valid && st.out_free)
                begin
                    cmd.take_in = 1'b1;
                    unique case (st.kind)
                        KIND_EMIT:
                        begin
                            cmd.load_out = 1'b1;
                            cmd.out_sel  = SEL_IN;
                            cmd.out_last = 1'b1;
                        end
                        KIND_SPACE:
                        begin
                            cmd.load_out = 1'b1;
                            cmd.out_sel  = SEL_SPACE;
                            state_next   = S_SPACE2;
                        end
                        KIND_COPY:
                        begin
                            state_next = S_COPY_RD;
                        end
                        KIND_BAD:
                        begin
                            cmd.load_out = 1'b1;
                            cmd.out_sel  = SEL_ERR;
                            cmd.out_last = 1'b1;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SPACE2:
            begin
                if (st.out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.out_sel  = SEL_FLIP;
                    cmd.out_last = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_COPY_RD:
            begin
                state_next = S_COPY_WR;
            end
            S_COPY_WR:
            begin
                if (st.out_free)
                begin
                    cmd.load_out  = 1'b1;
                    cmd.out_sel   = SEL_HIST;
                    cmd.out_last  = st.copy_last;
                    cmd.copy_step = 1'b1;
                    state_next    = st.copy_last ? S_IDLE : S_COPY_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/lz77_text_record_decoder.sv]
// ----------------------------------------------------------------------------
// lz77_text_record_decoder
// Decompresses text records coded with the small LZ77 scheme of e-book text
// records, one compressed byte per input item, one decoded byte per output.
//
//   channel  dir  tdata              tuser            tlast
//   s_axis   in   [7:0] data_byte    [0] start_of_record  -
//   m_axis   out  [7:0] out_byte     [0] bad_reference    last_of_run
//
// literal or raw byte: emitted directly; space pair: space then flipped byte;
// n-byte back-reference copy: one history memory read then one write per byte
// after reset the history is unknown, reads never reach unwritten entries
// output register stalls hold the sequence; input waits while it is held full
// ----------------------------------------------------------------------------
module lz77_text_record_decoder
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic [0:0] s_tuser,   // [0] start_of_record
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [0:0] m_tuser,   // [0] bad_reference
    output logic       m_tlast
);
    import lz77trd_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t st;
    logic       bad;

    lz77trd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    lz77trd_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_byte   (s_tdata),
        .in_sor    (s_tuser[0]),
        .cmd       (cmd),
        .st        (st),
        .out_valid (m_tvalid),
        .out_byte  (m_tdata),
        .out_last  (m_tlast),
        .out_bad   (bad),
        .out_ready (m_tready)
    );

    assign m_tuser = bad;

endmodule

[rtl/lz77trd_chk.sv]
// ----------------------------------------------------------------------------
// lz77trd_chk
// Port-level checks for the text record decoder, bound to the top level.
// ----------------------------------------------------------------------------
module lz77trd_chk
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic [0:0] s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [0:0] m_tuser,
    input logic       m_tlast
);

    // error item is a lone zero byte ending its run
    a_bad_item: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tlast && (m_tdata == 8'h00))
        else $error("error item malformed");

    // no new item taken while a result is stuck in the output register
    a_no_take_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted during output stall");

    // literal opening a record comes out next cycle unchanged
    a_literal_pass: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser[0] && !s_tdata[7] &&
        ((s_tdata == 8'h00) || (s_tdata >= 8'h09))
        |=> m_tvalid && m_tlast && !m_tuser[0] && (m_tdata == $past(s_tdata)))
        else $error("literal not passed through");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output changed during stall");

endmodule

bind lz77_text_record_decoder lz77trd_chk u_lz77trd_chk
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
